[hdl/sla_pkg.sv]
// ----------------------------------------------------------------------------
// sla_pkg
// Shared widths, constants and the command/status types that join the
// split line allocator controller to its datapath.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int LINE_W      = 12;
    localparam int LINE_EXT_W  = LINE_W + 1;
    localparam int PANE_IDX_W  = 6;
    localparam int POS_W       = 4;
    localparam int DIV_STEPS   = LINE_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [LINE_W-1:0] TOTAL_LINES_RESET = 12'd24;
    localparam logic [LINE_W-1:0] FRAME_LINES       = 12'd1;

    typedef struct packed {
        logic load_en;
        logic prep;
        logic sweep_clr;
        logic sweep_rd;
        logic acc_en;
        logic measure;
        logic search_eval;
        logic measure_eval;
        logic div_start;
        logic out_mode;
        logic out_rd;
        logic finish;
    } sla_cmd_t;

    typedef struct packed {
        logic last_taken;
        logic over_budget;
        logic idx_end;
        logic rd_pend;
        logic pos_zero;
        logic div_busy;
        logic out_free;
    } sla_status_t;

endpackage

[hdl/sla_ifs.sv]
// ----------------------------------------------------------------------------
// sla_ifs
// Valid/ready channels of the split line allocator: pane requests in,
// pane results out, and the total line configuration write channel.
// ----------------------------------------------------------------------------
interface sla_pane_if;
    logic                        valid;
    logic                        ready;
    logic [sla_pkg::LINE_W-1:0]  minimum_lines;
    logic                        last;

    modport source (output valid, minimum_lines, last, input ready);
    modport sink   (input valid, minimum_lines, last, output ready);
endinterface

interface sla_result_if;
    logic                           valid;
    logic                           ready;
    logic [sla_pkg::PANE_IDX_W-1:0] pane_index;
    logic [sla_pkg::LINE_W-1:0]     share_lines;
    logic [sla_pkg::LINE_W-1:0]     content_lines;
    logic                           last_result;

    modport source (output valid, pane_index, share_lines, content_lines, last_result,
                    input ready);
    modport sink   (input valid, pane_index, share_lines, content_lines, last_result,
                    output ready);
endinterface

interface sla_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sla_pkg::LINE_W-1:0]  total_lines;

    modport source (output valid, total_lines, input ready);
    modport sink   (input valid, total_lines, output ready);
endinterface

[hdl/sla_ram.sv]
// ----------------------------------------------------------------------------
// sla_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sla_ram #(
    parameter int WIDTH  = 12,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/sla_div.sv]
// ----------------------------------------------------------------------------
// sla_div
// Restoring divider: one quotient bit per cycle for a line-count dividend
// divided by the pane count.
// ----------------------------------------------------------------------------
module sla_div #(
    parameter int DIV_W = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sla_pkg::LINE_W-1:0] dividend,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       busy,
    output logic [sla_pkg::LINE_W-1:0] quotient,
    output logic [DIV_W-1:0]           remainder
);

    logic [sla_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic [sla_pkg::LINE_W-1:0]    quot_reg;
    logic [DIV_W-1:0]              rem_reg;
    logic [DIV_W:0]                rem_shift;
    logic [DIV_W:0]                rem_diff;
    logic                          fits;

    assign rem_shift = {rem_reg, quot_reg[sla_pkg::LINE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= sla_pkg::DIV_CNT_W'(sla_pkg::DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == sla_pkg::DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[sla_pkg::LINE_W-2:0], fits};
            rem_reg  <= fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

[hdl/sla_datapath.sv]
// ----------------------------------------------------------------------------
// sla_datapath
// Pane store, load counters, cap search accumulator, spread divider and the
// result register of the split line allocator.
// ----------------------------------------------------------------------------
module sla_datapath #(
    parameter int MAX_PANES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sla_pkg::sla_cmd_t    cmd,
    output sla_pkg::sla_status_t status,
    sla_pane_if.sink             pane,
    sla_result_if.source         result,
    sla_cfg_if.sink              cfg
);

    localparam int CNT_W  = $clog2(MAX_PANES + 1);
    localparam int ADDR_W = (MAX_PANES > 1) ? $clog2(MAX_PANES) : 1;
    localparam int SUM_W  = CNT_W + sla_pkg::LINE_W;
    localparam int LW     = sla_pkg::LINE_W;
    localparam int EW     = sla_pkg::LINE_EXT_W;

    logic [LW-1:0]     total_cfg_reg;
    logic [LW-1:0]     budget_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  nz_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic              rd_pend_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [LW-1:0]     c_reg;
    logic [sla_pkg::POS_W-1:0] pos_reg;
    logic              shrink_reg;
    logic [CNT_W-1:0]  excess_reg;

    logic                         out_valid_reg;
    logic [sla_pkg::PANE_IDX_W-1:0] out_index_reg;
    logic [LW-1:0]                out_share_reg;
    logic [LW-1:0]                out_content_reg;
    logic                         out_last_reg;

    logic              pane_take;
    logic              store_ok;
    logic              multi;
    logic [LW-1:0]     ram_rdata;
    logic [EW-1:0]     rd_line;
    logic [SUM_W-1:0]  total;
    logic              over_budget;
    logic [EW-1:0]     search_trial;
    logic [EW-1:0]     cap;
    logic [EW-1:0]     trial;
    logic [EW-1:0]     clipped;
    logic              rd_issue;
    logic [CNT_W-1:0]  rd_pos;
    logic [EW-1:0]     val;
    logic [EW-1:0]     content;
    logic              take_excess;
    logic              out_load;
    logic [LW-1:0]     spare;
    logic              div_busy;
    logic [LW-1:0]     quot;
    logic [CNT_W-1:0]  rmd;

    assign pane_take = pane.valid && cmd.load_en;
    assign pane.ready = cmd.load_en;
    assign cfg.ready  = 1'b1;

    assign store_ok = count_reg < CNT_W'(MAX_PANES);
    assign multi    = count_reg > CNT_W'(1);

    // Each nonzero pane of a multi-pane set carries one frame line on top of its minimum.
    assign rd_line = {1'b0, ram_rdata}
                   + EW'(multi && (ram_rdata != '0) ? sla_pkg::FRAME_LINES : '0);
    assign total       = sum_reg + (multi ? SUM_W'(nz_reg) : '0);
    assign over_budget = total > SUM_W'(budget_reg);
    assign spare       = LW'(SUM_W'(budget_reg) - total);

    // The shrink pass gives each pane min(height, cap), or cap - 1 while excess is
    // left; search finds the largest fitting clip, one bit per sweep; cap = clip + 1.
    assign search_trial = {1'b0, c_reg | (LW'(1) << pos_reg)};
    assign cap          = {1'b0, c_reg} + EW'(1);
    assign trial        = cmd.measure ? cap : search_trial;
    assign clipped      = (rd_line < trial) ? rd_line : trial;

    assign rd_issue = cmd.sweep_rd || cmd.out_rd;
    assign rd_pos   = CNT_W'(rd_idx_reg);
    assign out_load = cmd.out_mode && rd_pend_reg;

    always_comb
    begin
        take_excess = 1'b0;
        if (shrink_reg)
        begin
            if (rd_line >= cap)
            begin
                if (excess_reg != '0)
                begin
                    val         = {1'b0, c_reg};
                    take_excess = 1'b1;
                end
                else
                begin
                    val = cap;
                end
            end
            else
            begin
                val = rd_line;
            end
        end
        else
        begin
            val = rd_line + {1'b0, quot} + EW'(rd_pos < rmd);
        end

        if (multi)
        begin
            content = (val > EW'(sla_pkg::FRAME_LINES)) ? val - EW'(sla_pkg::FRAME_LINES) : '0;
        end
        else
        begin
            content = val;
        end
    end

    sla_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_PANES)
    ) u_store (
        .clk   (clk),
        .we    (pane_take && store_ok),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (pane.minimum_lines),
        .re    (rd_issue),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    sla_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (spare),
        .divisor   (count_reg),
        .busy      (div_busy),
        .quotient  (quot),
        .remainder (rmd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_cfg_reg <= sla_pkg::TOTAL_LINES_RESET;
            count_reg     <= '0;
            nz_reg        <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            shrink_reg    <= 1'b0;
            excess_reg    <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                total_cfg_reg <= cfg.total_lines;
            end

            if (cmd.finish)
            begin
                count_reg <= '0;
                nz_reg    <= '0;
                sum_reg   <= '0;
            end
            else if (pane_take && store_ok)
            begin
                count_reg <= count_reg + 1'b1;
                nz_reg    <= nz_reg + CNT_W'(pane.minimum_lines != '0);
                sum_reg   <= sum_reg + SUM_W'(pane.minimum_lines);
            end

            if (cmd.sweep_clr)
            begin
                idx_reg <= '0;
            end
            else if (rd_issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            rd_pend_reg <= rd_issue;

            if (cmd.prep)
            begin
                shrink_reg <= over_budget;
                pos_reg    <= sla_pkg::POS_W'(LW - 1);
            end
            else if (cmd.search_eval)
            begin
                pos_reg <= pos_reg - 1'b1;
            end

            if (cmd.measure_eval)
            begin
                excess_reg <= CNT_W'(acc_reg - SUM_W'(budget_reg));
            end
            else if (out_load && take_excess)
            begin
                excess_reg <= excess_reg - 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pane_take && pane.last)
        begin
            budget_reg <= total_cfg_reg;
        end

        if (cmd.sweep_clr)
        begin
            acc_reg <= '0;
        end
        else if (rd_pend_reg && cmd.acc_en)
        begin
            acc_reg <= acc_reg + SUM_W'(clipped);
        end

        if (rd_issue)
        begin
            rd_idx_reg <= idx_reg[ADDR_W-1:0];
        end

        if (cmd.prep)
        begin
            c_reg <= '0;
        end
        else if (cmd.search_eval && (acc_reg <= SUM_W'(budget_reg)))
        begin
            c_reg <= search_trial[LW-1:0];
        end

        if (out_load)
        begin
            out_index_reg   <= sla_pkg::PANE_IDX_W'(rd_idx_reg);
            out_share_reg   <= val[LW-1:0];
            out_content_reg <= content[LW-1:0];
            out_last_reg    <= (rd_pos + 1'b1) == count_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.pane_index    = out_index_reg;
    assign result.share_lines   = out_share_reg;
    assign result.content_lines = out_content_reg;
    assign result.last_result   = out_last_reg;

    assign status.last_taken  = pane_take && pane.last;
    assign status.over_budget = over_budget;
    assign status.idx_end     = idx_reg == count_reg;
    assign status.rd_pend     = rd_pend_reg;
    assign status.pos_zero    = pos_reg == '0;
    assign status.div_busy    = div_busy;
    assign status.out_free    = !out_valid_reg || result.ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PANES))
        else $error("pane count ran past the store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg)
        else $error("result register overwritten while still full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_mode && shrink_reg) |-> (excess_reg <= count_reg))
        else $error("shrink excess larger than the pane count");

endmodule

[hdl/sla_ctrl.sv]
// ----------------------------------------------------------------------------
// sla_ctrl
// Sequencer of the split line allocator: load, cap search sweeps, spread
// division and the result sweep.
// ----------------------------------------------------------------------------
module sla_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sla_pkg::sla_status_t status,
    output sla_pkg::sla_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SRCH,
        ST_SRCH_EVAL,
        ST_MEAS,
        ST_MEAS_EVAL,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   sweep_done;

    assign sweep_done = status.idx_end && !status.rd_pend;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_en   = 1'b1;
                cmd.sweep_clr = 1'b1;
                if (status.last_taken)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep      = 1'b1;
                cmd.sweep_clr = 1'b1;
                if (status.over_budget)
                begin
                    state_next = ST_SRCH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_SRCH:
            begin
                cmd.acc_en   = 1'b1;
                cmd.sweep_rd = !status.idx_end;
                if (sweep_done)
                begin
                    state_next = ST_SRCH_EVAL;
                end
            end
            ST_SRCH_EVAL:
            begin
                cmd.search_eval = 1'b1;
                cmd.sweep_clr   = 1'b1;
                state_next      = status.pos_zero ? ST_MEAS : ST_SRCH;
            end
            ST_MEAS:
            begin
                cmd.acc_en   = 1'b1;
                cmd.measure  = 1'b1;
                cmd.sweep_rd = !status.idx_end;
                if (sweep_done)
                begin
                    state_next = ST_MEAS_EVAL;
                end
            end
            ST_MEAS_EVAL:
            begin
                cmd.measure_eval = 1'b1;
                cmd.sweep_clr    = 1'b1;
                state_next       = ST_OUTPUT;
            end
            ST_DIVIDE:
            begin
                cmd.sweep_clr = 1'b1;
                if (!status.div_busy)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                cmd.out_mode = 1'b1;
                cmd.out_rd   = !status.idx_end && !status.rd_pend && status.out_free;
                if (sweep_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/split_line_allocator_unit.sv]
// ----------------------------------------------------------------------------
// split_line_allocator_unit
// Panes are loaded one request per cycle while the unit is idle into a pane
// store, each with its minimum height; the request with last set closes the
// set and latches the line budget. With more than one pane every nonzero
// minimum gains a frame line. If the set fits, the spare lines are divided by
// the pane count in a restoring divider and spread evenly, the remainder going
// one each to the first panes. If it does not fit, the height cap one above
// the largest clip that fits is found by a binary search of 12 sweeps over the
// store plus one measuring sweep; the panes at the cap then give up the
// excess lines, one each in index order. Results leave through a registered
// output while the sink is ready; a new store read waits until the previous
// one has reached the output register. No new pane is taken until the whole
// set has been delivered to the output register. Panes beyond MAX_PANES are
// dropped.
// ----------------------------------------------------------------------------
module split_line_allocator_unit #(
    parameter int MAX_PANES = 16
) (
    input logic          clk,
    input logic          rst_n,
    sla_pane_if.sink     pane,
    sla_result_if.source result,
    sla_cfg_if.sink      cfg
);

    sla_pkg::sla_cmd_t    cmd;
    sla_pkg::sla_status_t status;

    sla_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sla_datapath #(
        .MAX_PANES (MAX_PANES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .pane   (pane),
        .result (result),
        .cfg    (cfg)
    );

endmodule
